>>> sv/tcsb_pkg.sv
package tcsb_pkg;

    // store geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = ROWS * COLUMNS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int CURSOR_W = $clog2(COLUMNS + 1);
    localparam int CELL_W   = 8;

    // item kinds
    localparam logic [1:0] KIND_PRINT = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // byte codes
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_FIRST   = 8'd32;
    localparam logic [7:0] CHAR_LAST    = 8'd126;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [ROW_W-1:0]    prow_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [CURSOR_W-1:0] cursor_t;
    typedef logic [CELL_W-1:0]   cell_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic print_write;
        logic scroll;
        logic tab;
        logic clear;
        logic sweep_step;
        logic read_issue;
        logic read_capture;
        logic out_load;
    } tcsb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_print;
        logic is_read;
        logic is_clear;
        logic is_newline;
        logic is_tab;
        logic is_printable;
        logic at_edge;
        logic sweep_last;
        logic out_free;
    } tcsb_status_t;

endpackage

>>> sv/tcsb_ram.sv
module tcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/tcsb_ctrl.sv
module tcsb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  tcsb_pkg::tcsb_status_t status,
    output tcsb_pkg::tcsb_cmd_t    cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                if (status.is_print)
                begin
                    if (status.is_newline)
                    begin
                        cmd.scroll = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    else if (status.is_tab)
                    begin
                        cmd.tab = 1'b1;
                    end
                    else if (status.is_printable)
                    begin
                        if (status.at_edge)
                        begin
                            cmd.scroll = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        else
                        begin
                            cmd.print_write = 1'b1;
                        end
                    end
                end
                else if (status.is_read)
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = ST_RDWAIT;
                end
                else if (status.is_clear)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RDWAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register, reset starts the bottom-row clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/tcsb_dp.sv
module tcsb_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             kind,
    input  logic [7:0]             char_code,
    input  logic [4:0]             row,
    input  logic [6:0]             column,
    input  tcsb_pkg::tcsb_cmd_t    cmd,
    output tcsb_pkg::tcsb_status_t status,
    output logic                   ram_we,
    output tcsb_pkg::addr_t        ram_waddr,
    output tcsb_pkg::cell_t        ram_wdata,
    output logic                   ram_re,
    output tcsb_pkg::addr_t        ram_raddr,
    input  tcsb_pkg::cell_t        ram_rdata,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [7:0]             read_data,
    output logic [6:0]             cursor_column
);

    // item held for the duration of its work
    logic [1:0] kind_reg;
    logic [7:0] char_reg;
    logic [4:0] row_reg;
    logic [6:0] column_reg;

    // control state
    tcsb_pkg::cursor_t         cursor_reg, cursor_next;
    tcsb_pkg::prow_t           top_reg, top_next;
    tcsb_pkg::prow_t           bottom_reg, bottom_next;
    logic [tcsb_pkg::ROWS-1:0] row_valid_reg, row_valid_next;
    tcsb_pkg::col_t            sweep_reg, sweep_next;
    logic                      wrap_reg, wrap_next;
    logic                      out_valid_reg, out_valid_next;

    // payload
    logic            hit_reg;
    tcsb_pkg::cell_t data_reg;
    logic [7:0]      read_data_reg;
    logic [6:0]      cursor_column_reg;

    // derived values
    logic [tcsb_pkg::CURSOR_W:0] tab_sum;
    tcsb_pkg::cursor_t           tab_cursor;
    logic [7:0]                  row_sum;
    logic [7:0]                  phys_wide;
    tcsb_pkg::prow_t             phys_row;
    logic                        in_range;
    logic                        hit;
    tcsb_pkg::addr_t             bottom_base;
    logic [tcsb_pkg::CURSOR_W+7:0] cursor_ext;

    // decode of the held item
    assign status.is_print     = (kind_reg == tcsb_pkg::KIND_PRINT);
    assign status.is_read      = (kind_reg == tcsb_pkg::KIND_READ);
    assign status.is_clear     = (kind_reg == tcsb_pkg::KIND_CLEAR);
    assign status.is_newline   = (char_reg == tcsb_pkg::CHAR_NEWLINE);
    assign status.is_tab       = (char_reg == tcsb_pkg::CHAR_TAB);
    assign status.is_printable = (char_reg >= tcsb_pkg::CHAR_FIRST)
                               && (char_reg <= tcsb_pkg::CHAR_LAST);
    assign status.at_edge      = (cursor_reg >= tcsb_pkg::CURSOR_W'(tcsb_pkg::COLUMNS));
    assign status.sweep_last   = (sweep_reg == tcsb_pkg::COL_W'(tcsb_pkg::COLUMNS - 1));
    assign status.out_free     = !out_valid_reg || !result_stall;

    // tab rounds up to a multiple of four, saturating at the right edge
    assign tab_sum    = ({1'b0, cursor_reg} + (tcsb_pkg::CURSOR_W + 1)'(4))
                      & ~(tcsb_pkg::CURSOR_W + 1)'(3);
    assign tab_cursor = (tab_sum > (tcsb_pkg::CURSOR_W + 1)'(tcsb_pkg::COLUMNS))
                      ? tcsb_pkg::CURSOR_W'(tcsb_pkg::COLUMNS)
                      : tab_sum[tcsb_pkg::CURSOR_W-1:0];

    // logical row to physical row through the top pointer
    assign row_sum   = 8'(top_reg) + 8'(row_reg);
    assign phys_wide = (row_sum >= 8'(tcsb_pkg::ROWS)) ? row_sum - 8'(tcsb_pkg::ROWS) : row_sum;
    assign phys_row  = phys_wide[tcsb_pkg::ROW_W-1:0];
    assign in_range  = (7'(row_reg) < 7'(tcsb_pkg::ROWS))
                     && (8'(column_reg) < 8'(tcsb_pkg::COLUMNS));
    assign hit       = in_range && row_valid_reg[phys_row];

    assign bottom_base = tcsb_pkg::ADDR_W'(bottom_reg) * tcsb_pkg::ADDR_W'(tcsb_pkg::COLUMNS);

    // memory ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = bottom_base + tcsb_pkg::ADDR_W'(sweep_reg);
        ram_wdata = '0;
        if (cmd.print_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = bottom_base + tcsb_pkg::ADDR_W'(cursor_reg);
            ram_wdata = char_reg;
        end
        else if (cmd.sweep_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = (sweep_reg == '0 && wrap_reg) ? char_reg : '0;
        end
    end

    assign ram_re    = cmd.read_issue && hit;
    assign ram_raddr = tcsb_pkg::ADDR_W'(phys_row) * tcsb_pkg::ADDR_W'(tcsb_pkg::COLUMNS)
                     + tcsb_pkg::ADDR_W'(column_reg);

    // next values of the control state
    always_comb
    begin
        cursor_next    = cursor_reg;
        top_next       = top_reg;
        bottom_next    = bottom_reg;
        row_valid_next = row_valid_reg;
        sweep_next     = sweep_reg;
        wrap_next      = wrap_reg;
        out_valid_next = out_valid_reg;

        if (cmd.print_write)
        begin
            cursor_next = cursor_reg + tcsb_pkg::CURSOR_W'(1);
        end
        if (cmd.tab)
        begin
            cursor_next = tab_cursor;
        end
        // scroll rotates the top pointer; the old top row becomes the bottom
        if (cmd.scroll)
        begin
            top_next    = (top_reg == tcsb_pkg::ROW_W'(tcsb_pkg::ROWS - 1))
                        ? '0 : top_reg + tcsb_pkg::ROW_W'(1);
            bottom_next = top_reg;
            row_valid_next[top_reg] = 1'b1;
            sweep_next  = '0;
            wrap_next   = !status.is_newline;
            cursor_next = status.is_newline ? '0 : tcsb_pkg::CURSOR_W'(1);
        end
        // clear drops every row but the bottom one, which is swept
        if (cmd.clear)
        begin
            row_valid_next             = '0;
            row_valid_next[bottom_reg] = 1'b1;
            sweep_next                 = '0;
            wrap_next                  = 1'b0;
            cursor_next                = '0;
        end
        if (cmd.sweep_step)
        begin
            sweep_next = status.sweep_last ? '0 : sweep_reg + tcsb_pkg::COL_W'(1);
        end
        // result beat handshake
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            top_reg       <= '0;
            bottom_reg    <= tcsb_pkg::ROW_W'(tcsb_pkg::ROWS - 1);
            row_valid_reg <= {1'b1, {(tcsb_pkg::ROWS - 1){1'b0}}};
            sweep_reg     <= '0;
            wrap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            top_reg       <= top_next;
            bottom_reg    <= bottom_next;
            row_valid_reg <= row_valid_next;
            sweep_reg     <= sweep_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cursor_ext = {8'd0, cursor_reg};

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg   <= kind;
            char_reg   <= char_code;
            row_reg    <= row;
            column_reg <= column;
            data_reg   <= '0;
        end
        if (cmd.read_issue)
        begin
            hit_reg <= hit;
        end
        if (cmd.read_capture)
        begin
            data_reg <= hit_reg ? ram_rdata : '0;
        end
        if (cmd.out_load)
        begin
            read_data_reg     <= data_reg;
            cursor_column_reg <= cursor_ext[6:0];
        end
    end

    assign result_valid  = out_valid_reg;
    assign read_data     = read_data_reg;
    assign cursor_column = cursor_column_reg;

endmodule

>>> sv/text_console_scroll_buffer_top.sv
// Text console scroll buffer: characters are printed into the bottom row of a
// ROWS by COLUMNS store, other items read one cell or clear the screen, and
// every item returns exactly one result beat. One item is worked at a time.
// A plain print, tab or ignored byte goes through the execute and finish
// states, a read adds a wait state for the registered memory read, and a
// newline, a wrap at the right edge or a clear adds a sweep: scrolling only
// rotates a top-row pointer, but the new bottom row is then swept one cell
// per cycle through the single write port of the cell memory, to zero but for
// a wrapped character in its first cell. Every row has a valid bit, so a clear
// drops all rows but the bottom at once. After reset the block clears the
// bottom row the same way and stalls input until it is done. The result
// register lets the next item be accepted while the previous beat is stalled.
module text_console_scroll_buffer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] kind,
    input  logic [7:0] char_code,
    input  logic [4:0] row,
    input  logic [6:0] column,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] read_data,
    output logic [6:0] cursor_column
);

    tcsb_pkg::tcsb_cmd_t    cmd;
    tcsb_pkg::tcsb_status_t status;

    logic            ram_we;
    tcsb_pkg::addr_t ram_waddr;
    tcsb_pkg::cell_t ram_wdata;
    logic            ram_re;
    tcsb_pkg::addr_t ram_raddr;
    tcsb_pkg::cell_t ram_rdata;

    tcsb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    tcsb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .char_code     (char_code),
        .row           (row),
        .column        (column),
        .cmd           (cmd),
        .status        (status),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .read_data     (read_data),
        .cursor_column (cursor_column)
    );

    tcsb_ram #(
        .WIDTH (tcsb_pkg::CELL_W),
        .DEPTH (tcsb_pkg::CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // an accepted beat always makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input accepted back to back");

    // the cell store is only written while no item can be accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> item_stall)
        else $error("cell write while idle");

    // a result is only loaded while the result register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid || !result_stall))
        else $error("result overwritten while stalled");

    // reported cursor never passes the right edge
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, cursor_column} <= 8'(tcsb_pkg::COLUMNS)))
        else $error("cursor beyond right edge");

endmodule
